// File: hw/rtl/slfd_pkg.sv
// Package with shared types and constants of the sync/length/Fletcher deframer.
package slfd_pkg;

  // Sync bytes that open every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Parser phases.
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_CLASS   = 3'd2;
  localparam logic [2:0] PH_IDENT   = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CKA     = 3'd6;
  localparam logic [2:0] PH_CKB     = 3'd7;

  // Result item kinds.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_END_GOOD = 2'd1;
  localparam logic [1:0] KIND_END_BAD  = 2'd2;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // One result item.
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] payload_length;
  } result_t;

endpackage

// File: hw/rtl/slfd_in_reg.sv
// Input register stage that holds one received byte until the parser takes it.
module slfd_in_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [slfd_pkg::IN_DATA_W-1:0] s_axis_tdata,   // rx_byte
  input  logic                           take,
  output logic                           byte_valid,
  output logic [7:0]                     byte_data
);
  import slfd_pkg::*;

  logic       held;
  logic [7:0] held_byte;

  // The stage is free when empty or when its item moves on this cycle.
  assign s_axis_tready = !held || take;
  assign byte_valid    = held;
  assign byte_data     = held_byte;

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_axis_tready) begin
      held <= s_axis_tvalid;
    end
  end

  // Byte register.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      held_byte <= s_axis_tdata[7:0];
    end
  end

endmodule

// File: hw/rtl/slfd_parser.sv
// Frame parser: phase state, header fields, Fletcher sums and result forming.
module slfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output slfd_pkg::result_t res
);
  import slfd_pkg::*;

  logic [2:0]  phase,      phase_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_ident, frame_ident_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  checksum_a, checksum_a_next;
  logic [7:0]  checksum_b, checksum_b_next;
  logic [7:0]  received_ck_a, received_ck_a_next;

  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] seen_inc;
  logic [15:0] length_full;

  // Fletcher step on the current byte, from the running sums.
  always_comb begin
    if (phase == PH_CLASS) begin
      sum_a = rx_byte;
      sum_b = rx_byte;
    end else begin
      sum_a = checksum_a + rx_byte;
      sum_b = checksum_b + sum_a;
    end
  end

  assign seen_inc    = bytes_seen + 16'd1;
  assign length_full = {rx_byte, frame_length[7:0]};

  // Next state and result for the byte in the input stage.
  always_comb begin
    phase_next         = phase;
    frame_class_next   = frame_class;
    frame_ident_next   = frame_ident;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    checksum_a_next    = checksum_a;
    checksum_b_next    = checksum_b;
    received_ck_a_next = received_ck_a;
    res_valid          = 1'b0;
    res.item_kind      = KIND_PAYLOAD;
    res.msg_class      = frame_class;
    res.msg_ident      = frame_ident;
    res.payload_byte   = rx_byte;
    res.payload_index  = bytes_seen;
    res.payload_length = frame_length;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // A repeated first sync byte keeps waiting for the second one.
        if (rx_byte == SYNC_SECOND) begin
          phase_next = PH_CLASS;
        end else if (rx_byte != SYNC_FIRST) begin
          phase_next = PH_HUNT;
        end
      end
      PH_CLASS: begin
        checksum_a_next  = sum_a;
        checksum_b_next  = sum_b;
        frame_class_next = rx_byte;
        phase_next       = PH_IDENT;
      end
      PH_IDENT: begin
        checksum_a_next  = sum_a;
        checksum_b_next  = sum_b;
        frame_ident_next = rx_byte;
        bytes_seen_next  = '0;
        phase_next       = PH_LENGTH;
      end
      PH_LENGTH: begin
        checksum_a_next = sum_a;
        checksum_b_next = sum_b;
        if (bytes_seen == '0) begin
          frame_length_next = {8'd0, rx_byte};
          bytes_seen_next   = 16'd1;
        end else begin
          // A zero length skips straight to the checksum bytes.
          frame_length_next = length_full;
          bytes_seen_next   = '0;
          phase_next        = (length_full == '0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        checksum_a_next = sum_a;
        checksum_b_next = sum_b;
        res_valid       = 1'b1;
        bytes_seen_next = seen_inc;
        if (seen_inc == frame_length) begin
          phase_next = PH_CKA;
        end
      end
      PH_CKA: begin
        received_ck_a_next = rx_byte;
        phase_next         = PH_CKB;
      end
      PH_CKB: begin
        res_valid         = 1'b1;
        res.item_kind     = ((received_ck_a == checksum_a) && (rx_byte == checksum_b))
                            ? KIND_END_GOOD : KIND_END_BAD;
        res.payload_byte  = '0;
        res.payload_index = '0;
        bytes_seen_next   = '0;
        phase_next        = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // State registers advance only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_class   <= '0;
      frame_ident   <= '0;
      frame_length  <= '0;
      bytes_seen    <= '0;
      checksum_a    <= '0;
      checksum_b    <= '0;
      received_ck_a <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_class   <= frame_class_next;
      frame_ident   <= frame_ident_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      checksum_a    <= checksum_a_next;
      checksum_b    <= checksum_b_next;
      received_ck_a <= received_ck_a_next;
    end
  end

endmodule

// File: hw/rtl/slfd_out_reg.sv
// Result register that drives the master-side stream.
module slfd_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic                            res_valid,
  input  slfd_pkg::result_t               res,
  output logic                            free,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [slfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // msg_class, msg_ident,
                                                         // payload_byte, payload_index,
                                                         // payload_length
  output logic [slfd_pkg::OUT_USER_W-1:0] m_axis_tuser   // item_kind
);
  import slfd_pkg::*;

  logic    full;
  result_t held;

  // Room for a new result when empty or when the held one leaves now.
  assign free          = !full || m_axis_tready;
  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {held.payload_length, held.payload_index, held.payload_byte,
                          held.msg_ident, held.msg_class};
  assign m_axis_tuser  = held.item_kind;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load && res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (free && load && res_valid) begin
      held <= res;
    end
  end

endmodule

// File: hw/rtl/sync_length_fletcher_deframer_top.sv
// Top level of the sync/length/Fletcher frame deframer.
// Each byte is held in the input register and its result item in the result register.
// Throughput: one byte per cycle; the parser consumes the input register
// whenever the result register is empty or being drained.
// Reset (synchronous, active high) empties both stages and puts the parser
// back to hunting for the first sync byte with all frame fields cleared.
module sync_length_fletcher_deframer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [slfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [slfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // msg_class, msg_ident,
                                                          // payload_byte, payload_index,
                                                          // payload_length
  output logic [slfd_pkg::OUT_USER_W-1:0] m_axis_tuser    // item_kind
);
  import slfd_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res;

  // A byte is consumed when one is held and the result register has room.
  assign step = byte_valid && out_free;

  slfd_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (step),
    .byte_valid    (byte_valid),
    .byte_data     (byte_data)
  );

  slfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  slfd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .res_valid     (res_valid),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/slfd_checker.sv
// Port-level checker for the deframer top level, with its bind statement.
module slfd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [slfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [slfd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import slfd_pkg::*;

  // The result stage is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result item valid right after reset");

  // Only the three defined kinds leave the block.
  a_kind_defined: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_END_GOOD ||
                       m_axis_tuser == KIND_END_BAD))
    else $error("undefined item kind");

  // A payload item lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |->
      (m_axis_tdata[39:24] < m_axis_tdata[55:40]))
    else $error("payload index beyond declared length");

  // End items carry zero byte and index.
  a_end_zeroed: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |-> (m_axis_tdata[39:16] == '0))
    else $error("end item with nonzero byte or index");

  // A stalled result item holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result item changed");

endmodule

bind sync_length_fletcher_deframer_top slfd_checker u_slfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
